// ----- src/fqd_pkg.sv -----
// fqd_pkg: widths, register indexes, microcode word layout and step codes
// shared by the filtered quadrature decoder modules
// no dependencies
package fqd_pkg;

	// field widths
	localparam int SAMPLE_BITS    = 15;
	localparam int POSITION_BITS  = 16;
	localparam int GAIN_BITS      = 10;
	localparam int HYS_BITS       = 15;
	localparam int CFG_DATA_BITS  = 15;
	localparam int CFG_INDEX_BITS = 2;

	// stream word widths, padded to whole bytes
	localparam int IN_TDATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((POSITION_BITS + 2 + 7) / 8) * 8;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_PASS_GAIN  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_PASS_GAIN = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HYSTERESIS     = 2'd2;

	// register reset values
	localparam logic [GAIN_BITS-1:0] LOW_PASS_GAIN_RST  = 10'd261;
	localparam logic [GAIN_BITS-1:0] HIGH_PASS_GAIN_RST = 10'd9;
	localparam logic [HYS_BITS-1:0]  HYSTERESIS_RST     = 15'd3000;

	// gain scale and exact reciprocal for the divide by the scale
	localparam int GAIN_SCALE  = 1000;
	localparam logic [GAIN_BITS-1:0] GAIN_MAX = GAIN_BITS'(GAIN_SCALE);
	localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
	localparam int RECIP_EXTRA = 10;
	localparam int RECIP_SHIFT = PROD_BITS + RECIP_EXTRA;
	localparam int RECIP_BITS  = PROD_BITS + 1;
	localparam logic [63:0] RECIP_WIDE =
		((64'd1 << RECIP_SHIFT) + 64'(GAIN_SCALE - 1)) / 64'(GAIN_SCALE);
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_WIDE);

	// comparison width for the schmitt trigger
	localparam int CMP_BITS = ((SAMPLE_BITS > HYS_BITS) ? SAMPLE_BITS : HYS_BITS) + 2;

	// transition codes: bit 4 old a, bit 5 old b, bit 0 new a, bit 1 new b
	localparam logic [7:0] CODE_FWD_0 = 8'h01;
	localparam logic [7:0] CODE_FWD_1 = 8'h13;
	localparam logic [7:0] CODE_FWD_2 = 8'h32;
	localparam logic [7:0] CODE_FWD_3 = 8'h20;
	localparam logic [7:0] CODE_REV_0 = 8'h02;
	localparam logic [7:0] CODE_REV_1 = 8'h23;
	localparam logic [7:0] CODE_REV_2 = 8'h31;
	localparam logic [7:0] CODE_REV_3 = 8'h10;

	// filter operation selects
	typedef logic [1:0] op_t;
	localparam op_t OP_LP_A = 2'd0;
	localparam op_t OP_LP_B = 2'd1;
	localparam op_t OP_HP_A = 2'd2;
	localparam op_t OP_HP_B = 2'd3;

	// microprogram steps
	localparam int STEP_BITS = 4;
	typedef logic [STEP_BITS-1:0] step_t;
	localparam step_t STEP_WAIT   = 4'd0;
	localparam step_t STEP_MUL_0  = 4'd1;
	localparam step_t STEP_MUL_1  = 4'd2;
	localparam step_t STEP_UPD_0  = 4'd3;
	localparam step_t STEP_UPD_1  = 4'd4;
	localparam step_t STEP_MUL_2  = 4'd5;
	localparam step_t STEP_UPD_2  = 4'd6;
	localparam step_t STEP_UPD_3  = 4'd7;
	localparam step_t STEP_DECIDE = 4'd8;

	// one control word of the microprogram
	typedef struct packed {
		logic wait_in;
		logic wait_out;
		logic end_prog;
		logic mul_en;
		op_t  mul_op;
		logic rcp_en;
		logic upd_en;
		op_t  upd_op;
		logic decide;
	} ctrl_word_t;

	// datapath strobes issued by the sequencer
	typedef struct packed {
		logic load;
		logic mul_en;
		op_t  mul_op;
		logic rcp_en;
		logic upd_en;
		op_t  upd_op;
		logic decide;
	} dp_ctrl_t;

	// values of one result word
	typedef struct packed {
		logic signed [POSITION_BITS-1:0] position;
		logic level_a;
		logic level_b;
	} result_t;

endpackage

// ----- src/fqd_rom.sv -----
// fqd_rom: read-only control store of the decoder microprogram
// depends on fqd_pkg
module fqd_rom (
	input  fqd_pkg::step_t     step,
	output fqd_pkg::ctrl_word_t word
);

	// one control word per step; the multiply, reciprocal and update
	// stages overlap across the four filter operations
	always_comb begin
		word = '0;
		case (step)
			fqd_pkg::STEP_WAIT: begin
				word.wait_in = 1'b1;
			end
			fqd_pkg::STEP_MUL_0: begin
				word.mul_en = 1'b1;
				word.mul_op = fqd_pkg::OP_LP_A;
			end
			fqd_pkg::STEP_MUL_1: begin
				word.mul_en = 1'b1;
				word.mul_op = fqd_pkg::OP_LP_B;
				word.rcp_en = 1'b1;
			end
			fqd_pkg::STEP_UPD_0: begin
				word.rcp_en = 1'b1;
				word.upd_en = 1'b1;
				word.upd_op = fqd_pkg::OP_LP_A;
			end
			fqd_pkg::STEP_UPD_1: begin
				word.upd_en = 1'b1;
				word.upd_op = fqd_pkg::OP_LP_B;
				word.mul_en = 1'b1;
				word.mul_op = fqd_pkg::OP_HP_A;
			end
			fqd_pkg::STEP_MUL_2: begin
				word.mul_en = 1'b1;
				word.mul_op = fqd_pkg::OP_HP_B;
				word.rcp_en = 1'b1;
			end
			fqd_pkg::STEP_UPD_2: begin
				word.rcp_en = 1'b1;
				word.upd_en = 1'b1;
				word.upd_op = fqd_pkg::OP_HP_A;
			end
			fqd_pkg::STEP_UPD_3: begin
				word.upd_en = 1'b1;
				word.upd_op = fqd_pkg::OP_HP_B;
			end
			fqd_pkg::STEP_DECIDE: begin
				word.wait_out = 1'b1;
				word.decide   = 1'b1;
				word.end_prog = 1'b1;
			end
			default: begin
				word.end_prog = 1'b1;
			end
		endcase
	end

endmodule

// ----- src/fqd_datapath.sv -----
// fqd_datapath: configuration registers, filter state, shared gain multiplier,
// divide-by-scale reciprocal stage, schmitt triggers and position counter
// depends on fqd_pkg
module fqd_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fqd_pkg::dp_ctrl_t                     ctrl,
	input  logic [fqd_pkg::SAMPLE_BITS-1:0]       sample_a,
	input  logic [fqd_pkg::SAMPLE_BITS-1:0]       sample_b,
	input  logic                                 cfg_we,
	input  logic [fqd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [fqd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	output fqd_pkg::result_t                      result
);

	localparam int SB = fqd_pkg::SAMPLE_BITS;
	localparam int PB = fqd_pkg::PROD_BITS;
	localparam int CB = fqd_pkg::CMP_BITS;
	localparam int FB = fqd_pkg::PROD_BITS + fqd_pkg::RECIP_BITS;

	logic [fqd_pkg::GAIN_BITS-1:0] lpg_q, hpg_q;
	logic [fqd_pkg::HYS_BITS-1:0]  hys_q;
	logic [SB-1:0] smp_a_q, smp_b_q;
	logic [SB-1:0] lp_a_q, lp_b_q, hp_a_q, hp_b_q;
	logic          trig_a_q, trig_b_q;
	logic signed [2:0] phase_q;
	logic [fqd_pkg::POSITION_BITS-1:0] pos_q;

	logic [PB-1:0] prod_s1;
	logic          neg_s1;
	logic [SB-1:0] quo_s2;
	logic          neg_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpg_q <= fqd_pkg::LOW_PASS_GAIN_RST;
			hpg_q <= fqd_pkg::HIGH_PASS_GAIN_RST;
			hys_q <= fqd_pkg::HYSTERESIS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fqd_pkg::REG_LOW_PASS_GAIN:  lpg_q <= cfg_data[fqd_pkg::GAIN_BITS-1:0];
				fqd_pkg::REG_HIGH_PASS_GAIN: hpg_q <= cfg_data[fqd_pkg::GAIN_BITS-1:0];
				fqd_pkg::REG_HYSTERESIS:     hys_q <= cfg_data[fqd_pkg::HYS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sample capture on word accept
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			smp_a_q <= sample_a;
			smp_b_q <= sample_b;
		end
	end

	// gains above the scale act as the scale
	logic [fqd_pkg::GAIN_BITS-1:0] lpg_c, hpg_c;
	assign lpg_c = (lpg_q > fqd_pkg::GAIN_MAX) ? fqd_pkg::GAIN_MAX : lpg_q;
	assign hpg_c = (hpg_q > fqd_pkg::GAIN_MAX) ? fqd_pkg::GAIN_MAX : hpg_q;

	// operand select for the shared multiplier
	logic [SB-1:0] op_min, op_sub, mag;
	logic [fqd_pkg::GAIN_BITS-1:0] op_gain;
	logic [SB:0]   diff, diff_neg;
	logic [PB-1:0] prod;
	always_comb begin
		case (ctrl.mul_op)
			fqd_pkg::OP_LP_A: begin
				op_min = smp_a_q; op_sub = lp_a_q; op_gain = lpg_c;
			end
			fqd_pkg::OP_LP_B: begin
				op_min = smp_b_q; op_sub = lp_b_q; op_gain = lpg_c;
			end
			fqd_pkg::OP_HP_A: begin
				op_min = lp_a_q; op_sub = hp_a_q; op_gain = hpg_c;
			end
			default: begin
				op_min = lp_b_q; op_sub = hp_b_q; op_gain = hpg_c;
			end
		endcase
		diff     = {1'b0, op_min} - {1'b0, op_sub};
		diff_neg = -diff;
		mag      = diff[SB] ? diff_neg[SB-1:0] : diff[SB-1:0];
		prod     = PB'(op_gain) * PB'(mag);
	end

	// multiply stage: magnitude of gain times difference
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= prod;
			neg_s1  <= diff[SB];
		end
	end

	// reciprocal stage: exact floor division of the magnitude by the scale
	logic [FB-1:0] rcp_full;
	assign rcp_full = FB'(prod_s1) * FB'(fqd_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (ctrl.rcp_en) begin
			quo_s2 <= rcp_full[fqd_pkg::RECIP_SHIFT +: SB];
			neg_s2 <= neg_s1;
		end
	end

	// signed step, truncated toward zero; the filter stays in range
	logic [SB-1:0] step_val;
	assign step_val = neg_s2 ? (-quo_s2) : quo_s2;

	// schmitt trigger inputs from the updated filters
	logic signed [CB-1:0] out_a, out_b, hys_pos, hys_neg;
	logic new_a, new_b;
	always_comb begin
		out_a   = signed'(CB'(lp_a_q)) - signed'(CB'(hp_a_q));
		out_b   = signed'(CB'(lp_b_q)) - signed'(CB'(hp_b_q));
		hys_pos = signed'(CB'(hys_q));
		hys_neg = -hys_pos;
		if (out_a < hys_neg)      new_a = 1'b0;
		else if (out_a > hys_pos) new_a = 1'b1;
		else                      new_a = trig_a_q;
		if (out_b < hys_neg)      new_b = 1'b0;
		else if (out_b > hys_pos) new_b = 1'b1;
		else                      new_b = trig_b_q;
	end

	// transition code, phase and position update
	logic [7:0] code;
	logic signed [2:0] phase_sum, phase_next;
	logic [fqd_pkg::POSITION_BITS-1:0] pos_next;
	always_comb begin
		code = {2'b00, trig_b_q, trig_a_q, 2'b00, new_b, new_a};
		if (code inside {fqd_pkg::CODE_FWD_0, fqd_pkg::CODE_FWD_1,
				fqd_pkg::CODE_FWD_2, fqd_pkg::CODE_FWD_3}) begin
			phase_sum = phase_q + 3'sd1;
		end else if (code inside {fqd_pkg::CODE_REV_0, fqd_pkg::CODE_REV_1,
				fqd_pkg::CODE_REV_2, fqd_pkg::CODE_REV_3}) begin
			phase_sum = phase_q - 3'sd1;
		end else begin
			phase_sum = phase_q;
		end
		if (phase_sum >= 3'sd2) begin
			phase_next = phase_sum - 3'sd2;
			pos_next   = pos_q + fqd_pkg::POSITION_BITS'(1);
		end else if (phase_sum <= -3'sd2) begin
			phase_next = phase_sum + 3'sd2;
			pos_next   = pos_q - fqd_pkg::POSITION_BITS'(1);
		end else begin
			phase_next = phase_sum;
			pos_next   = pos_q;
		end
	end

	// filter, trigger and counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_a_q   <= '0;
			lp_b_q   <= '0;
			hp_a_q   <= '0;
			hp_b_q   <= '0;
			trig_a_q <= 1'b0;
			trig_b_q <= 1'b0;
			phase_q  <= '0;
			pos_q    <= '0;
		end else begin
			if (ctrl.upd_en) begin
				case (ctrl.upd_op)
					fqd_pkg::OP_LP_A: lp_a_q <= lp_a_q + step_val;
					fqd_pkg::OP_LP_B: lp_b_q <= lp_b_q + step_val;
					fqd_pkg::OP_HP_A: hp_a_q <= hp_a_q + step_val;
					default:          hp_b_q <= hp_b_q + step_val;
				endcase
			end
			if (ctrl.decide) begin
				trig_a_q <= new_a;
				trig_b_q <= new_b;
				phase_q  <= phase_next;
				pos_q    <= pos_next;
			end
		end
	end

	assign result.position = signed'(pos_next);
	assign result.level_a  = new_a;
	assign result.level_b  = new_b;

endmodule

// ----- src/filtered_quadrature_decoder.sv -----
// Filtered quadrature decoder: filters, schmitt triggers and quadrature phase decoding into
// a wrapping position count; depends on fqd_pkg, fqd_rom and fqd_datapath
// Timing: an accepted input word passes the multiply, reciprocal and update steps, then decide;
// a new word is taken only after the microprogram ends (one shared multiplier and reciprocal
// stage serve the four filter steps), and the decide step waits while a result word waits.
// Reset: arst_n clears filters, triggers, phase, position, step counter; registers to defaults.
module filtered_quadrature_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// sample_a, sample_b, zero padding
	input  logic [fqd_pkg::IN_TDATA_BITS-1:0]      s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// position, level_a, level_b, zero padding
	output logic [fqd_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
	input  logic                                  cfg_we,
	input  logic [fqd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [fqd_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int SB = fqd_pkg::SAMPLE_BITS;

	fqd_pkg::step_t      step_q;
	fqd_pkg::ctrl_word_t word;
	fqd_pkg::dp_ctrl_t   dp_ctrl;
	fqd_pkg::result_t    result;
	fqd_pkg::result_t    out_q;
	logic                out_valid_q;
	logic                s_accept, out_free, advance;

	// control store
	fqd_rom u_rom (
		.step (step_q),
		.word (word)
	);

	// step conditions
	assign s_tready = word.wait_in;
	assign s_accept = s_tvalid & s_tready;
	assign out_free = ~out_valid_q | m_tready;
	assign advance  = word.wait_in ? s_accept : (word.wait_out ? out_free : 1'b1);

	// step counter with jump back to the wait step at program end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= fqd_pkg::STEP_WAIT;
		end else if (advance) begin
			step_q <= word.end_prog ? fqd_pkg::STEP_WAIT : step_q + fqd_pkg::step_t'(1);
		end
	end

	// datapath strobes
	always_comb begin
		dp_ctrl.load   = s_accept;
		dp_ctrl.mul_en = word.mul_en;
		dp_ctrl.mul_op = word.mul_op;
		dp_ctrl.rcp_en = word.rcp_en;
		dp_ctrl.upd_en = word.upd_en;
		dp_ctrl.upd_op = word.upd_op;
		dp_ctrl.decide = word.decide & advance;
	end

	fqd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (dp_ctrl),
		.sample_a  (s_tdata[SB-1:0]),
		.sample_b  (s_tdata[2*SB-1:SB]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_ctrl.decide) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.decide) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = fqd_pkg::OUT_TDATA_BITS'({out_q.level_b, out_q.level_a, out_q.position});

endmodule

// ----- bench/filtered_quadrature_decoder_test.sv -----
// self-checking bench for the filtered quadrature decoder: directed table, then random
// quadrature waveforms and noise under several register settings, checked by a predictor
// depends on fqd_pkg and filtered_quadrature_decoder
module filtered_quadrature_decoder_test;

	localparam int RANDOM_PAIRS  = 1750;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 10;

	typedef logic [fqd_pkg::CFG_DATA_BITS-1:0] cfg_value_t;

	// one row of the directed table: a sample pair or a register write
	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
	typedef struct packed {
		row_kind_t   kind;
		logic [15:0] a;         // sample_a, or register index
		logic [15:0] b;         // sample_b, or register value
		logic        typed;     // expected reading given in the row
		logic [15:0] position;
		logic        level_a;
		logic        level_b;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// sample_a, sample_b, zero padding
	logic [fqd_pkg::IN_TDATA_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// position, level_a, level_b, zero padding
	logic [fqd_pkg::OUT_TDATA_BITS-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [fqd_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [fqd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	// predictor state
	logic [fqd_pkg::GAIN_BITS-1:0]     lp_gain = fqd_pkg::LOW_PASS_GAIN_RST;
	logic [fqd_pkg::GAIN_BITS-1:0]     hp_gain = fqd_pkg::HIGH_PASS_GAIN_RST;
	logic [fqd_pkg::HYS_BITS-1:0]      hys_level = fqd_pkg::HYSTERESIS_RST;
	logic [fqd_pkg::SAMPLE_BITS-1:0]   lp_a = '0, lp_b = '0, hp_a = '0, hp_b = '0;
	logic                              trig_a = 1'b0, trig_b = 1'b0;
	int                                phase_acc = 0;
	logic [fqd_pkg::POSITION_BITS-1:0] position_acc = '0;

	fqd_pkg::result_t pending_readings [$];
	int mismatch_count = 0;
	int pairs_sent = 0;
	int burst_left = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int ready_count = 0;

	stim_row_t directed_rows [27] = '{
		'{ROW_SAMPLE, 0, 0, 1, 0, 0, 0},
		'{ROW_WRITE, fqd_pkg::REG_LOW_PASS_GAIN, 1000, 0, 0, 0, 0},
		'{ROW_WRITE, fqd_pkg::REG_HIGH_PASS_GAIN, 1000, 0, 0, 0, 0},
		// both filters settle on mid scale
		'{ROW_SAMPLE, 16384, 16384, 1, 0, 0, 0},
		// frozen high-pass: output is sample minus mid scale
		'{ROW_WRITE, fqd_pkg::REG_HIGH_PASS_GAIN, 0, 0, 0, 0, 0},
		'{ROW_WRITE, fqd_pkg::REG_HYSTERESIS, 3000, 0, 0, 0, 0},
		// one full forward cycle
		'{ROW_SAMPLE, 32767, 16384, 1, 0, 1, 0},
		'{ROW_SAMPLE, 32767, 32767, 1, 1, 1, 1},
		'{ROW_SAMPLE, 0, 32767, 1, 1, 0, 1},
		'{ROW_SAMPLE, 0, 0, 1, 2, 0, 0},
		// exactly on the thresholds: levels hold
		'{ROW_SAMPLE, 19384, 13384, 1, 2, 0, 0},
		'{ROW_SAMPLE, 19385, 16384, 1, 2, 1, 0},
		// both channels flip together, then neither
		'{ROW_SAMPLE, 13383, 32767, 1, 2, 0, 1},
		'{ROW_SAMPLE, 16384, 16384, 1, 2, 0, 1},
		// reverse through zero
		'{ROW_SAMPLE, 32767, 32767, 1, 2, 1, 1},
		'{ROW_SAMPLE, 32767, 0, 1, 2, 1, 0},
		'{ROW_SAMPLE, 0, 0, 1, 1, 0, 0},
		'{ROW_SAMPLE, 0, 32767, 1, 1, 0, 1},
		'{ROW_SAMPLE, 32767, 32767, 1, 0, 1, 1},
		'{ROW_SAMPLE, 32767, 0, 1, 0, 1, 0},
		'{ROW_SAMPLE, 0, 0, 1, 16'hFFFF, 0, 0},
		// gains above full scale behave as full scale
		'{ROW_WRITE, fqd_pkg::REG_HYSTERESIS, 0, 0, 0, 0, 0},
		'{ROW_WRITE, fqd_pkg::REG_LOW_PASS_GAIN, 1023, 0, 0, 0, 0},
		'{ROW_WRITE, fqd_pkg::REG_HIGH_PASS_GAIN, 1023, 0, 0, 0, 0},
		'{ROW_SAMPLE, 32767, 32767, 1, 16'hFFFF, 0, 0},
		// zero low-pass gain holds the filters
		'{ROW_WRITE, fqd_pkg::REG_LOW_PASS_GAIN, 0, 0, 0, 0, 0},
		'{ROW_SAMPLE, 5000, 20000, 1, 16'hFFFF, 0, 0}
	};

	filtered_quadrature_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	// one channel: low-pass, high-pass, schmitt trigger
	function automatic void filter_channel(input logic [fqd_pkg::SAMPLE_BITS-1:0] sample,
			inout logic [fqd_pkg::SAMPLE_BITS-1:0] lp,
			inout logic [fqd_pkg::SAMPLE_BITS-1:0] hp, inout logic level);
		longint g_lp, g_hp, lp_next, hp_next, out;
		g_lp = (lp_gain > fqd_pkg::GAIN_MAX) ? fqd_pkg::GAIN_SCALE : longint'(lp_gain);
		g_hp = (hp_gain > fqd_pkg::GAIN_MAX) ? fqd_pkg::GAIN_SCALE : longint'(hp_gain);
		lp_next = longint'(lp)
			+ g_lp * (longint'(sample) - longint'(lp)) / fqd_pkg::GAIN_SCALE;
		hp_next = longint'(hp) + g_hp * (lp_next - longint'(hp)) / fqd_pkg::GAIN_SCALE;
		out = lp_next - hp_next;
		if (out < -longint'(hys_level)) begin
			level = 1'b0;
		end else if (out > longint'(hys_level)) begin
			level = 1'b1;
		end
		lp = lp_next[fqd_pkg::SAMPLE_BITS-1:0];
		hp = hp_next[fqd_pkg::SAMPLE_BITS-1:0];
	endfunction

	// reading after one sample pair: filters, transition code, phase and position
	function automatic fqd_pkg::result_t decode_sample_pair(
			input logic [fqd_pkg::SAMPLE_BITS-1:0] a,
			input logic [fqd_pkg::SAMPLE_BITS-1:0] b);
		logic [7:0] code;
		fqd_pkg::result_t reading;
		code = '0;
		code[4] = trig_a;
		code[5] = trig_b;
		filter_channel(a, lp_a, hp_a, trig_a);
		filter_channel(b, lp_b, hp_b, trig_b);
		code[0] = trig_a;
		code[1] = trig_b;
		case (code)
			fqd_pkg::CODE_FWD_0, fqd_pkg::CODE_FWD_1,
			fqd_pkg::CODE_FWD_2, fqd_pkg::CODE_FWD_3: phase_acc++;
			fqd_pkg::CODE_REV_0, fqd_pkg::CODE_REV_1,
			fqd_pkg::CODE_REV_2, fqd_pkg::CODE_REV_3: phase_acc--;
			default: ;
		endcase
		if (phase_acc >= 2) begin
			phase_acc -= 2;
			position_acc++;
		end else if (phase_acc <= -2) begin
			phase_acc += 2;
			position_acc--;
		end
		reading.position = position_acc;
		reading.level_a = trig_a;
		reading.level_b = trig_b;
		return reading;
	endfunction

	function automatic logic [fqd_pkg::SAMPLE_BITS-1:0] jitter_level(input int level,
			input int noise);
		int v;
		v = level + int'($urandom_range(0, 2 * noise)) - noise;
		if (v < 0) v = 0;
		if (v > 32767) v = 32767;
		return v[fqd_pkg::SAMPLE_BITS-1:0];
	endfunction

	// register write, mirrored into the predictor
	task automatic write_register(input logic [fqd_pkg::CFG_INDEX_BITS-1:0] index,
			input logic [fqd_pkg::CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		case (index)
			fqd_pkg::REG_LOW_PASS_GAIN: lp_gain = value[fqd_pkg::GAIN_BITS-1:0];
			fqd_pkg::REG_HIGH_PASS_GAIN: hp_gain = value[fqd_pkg::GAIN_BITS-1:0];
			fqd_pkg::REG_HYSTERESIS: hys_level = value[fqd_pkg::HYS_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// stop sending and wait until every reading is back and the block is quiet
	task automatic settle_block();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// send one word in bursts with random gaps between them
	task automatic push_sample_pair(input logic [fqd_pkg::SAMPLE_BITS-1:0] a,
			input logic [fqd_pkg::SAMPLE_BITS-1:0] b, input logic typed,
			input fqd_pkg::result_t typed_reading);
		fqd_pkg::result_t predicted;
		int gap;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = fqd_pkg::IN_TDATA_BITS'({b, a});
		do @(posedge clk); while (!s_tready);
		predicted = decode_sample_pair(a, b);
		pending_readings.push_back(typed ? typed_reading : predicted);
		pairs_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 20);
		end
	endtask

	// receiver stalls on a rotating pattern, now and then ready throughout
	always @(negedge clk) begin
		if (ready_count == 0) begin
			ready_count = $urandom_range(32, 160);
			ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'd1);
		end
		ready_count--;
		ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
		m_tready = ready_pattern[0];
	end

	// result checker
	always @(posedge clk) begin
		fqd_pkg::result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.position = m_tdata[fqd_pkg::POSITION_BITS-1:0];
			got.level_a = m_tdata[fqd_pkg::POSITION_BITS];
			got.level_b = m_tdata[fqd_pkg::POSITION_BITS+1];
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected word: position %0d level_a %0b level_b %0b",
						got.position, got.level_a, got.level_b);
			end else begin
				want = pending_readings.pop_front();
				if (got.position !== want.position || got.level_a !== want.level_a ||
						got.level_b !== want.level_b) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
							want.position, want.level_a, want.level_b,
							got.position, got.level_a, got.level_b);
				end
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t row;
		fqd_pkg::result_t typed_reading;
		int seg_len, quarter_len, step_in_quarter, quadrant;
		int low_lvl, high_lvl, noise, random_start;
		bit forward;
		logic [fqd_pkg::SAMPLE_BITS-1:0] a, b;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < $size(directed_rows); i++) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				settle_block();
				write_register(row.a[fqd_pkg::CFG_INDEX_BITS-1:0],
					row.b[fqd_pkg::CFG_DATA_BITS-1:0]);
			end else begin
				typed_reading.position = row.position;
				typed_reading.level_a = row.level_a;
				typed_reading.level_b = row.level_b;
				push_sample_pair(row.a[fqd_pkg::SAMPLE_BITS-1:0],
					row.b[fqd_pkg::SAMPLE_BITS-1:0], row.typed, typed_reading);
			end
		end

		// random phases, each under a fresh register setting
		random_start = pairs_sent;
		while (pairs_sent - random_start < RANDOM_PAIRS) begin
			settle_block();
			case ($urandom_range(0, 9))
				0: write_register(fqd_pkg::REG_LOW_PASS_GAIN, cfg_value_t'(1000));
				1: write_register(fqd_pkg::REG_LOW_PASS_GAIN, cfg_value_t'(1023));
				default: write_register(fqd_pkg::REG_LOW_PASS_GAIN,
					cfg_value_t'($urandom_range(60, 900)));
			endcase
			case ($urandom_range(0, 9))
				0: write_register(fqd_pkg::REG_HIGH_PASS_GAIN, cfg_value_t'(0));
				1: write_register(fqd_pkg::REG_HIGH_PASS_GAIN, cfg_value_t'(1000));
				default: write_register(fqd_pkg::REG_HIGH_PASS_GAIN,
					cfg_value_t'($urandom_range(1, 60)));
			endcase
			case ($urandom_range(0, 7))
				0: write_register(fqd_pkg::REG_HYSTERESIS, cfg_value_t'(0));
				1: write_register(fqd_pkg::REG_HYSTERESIS, cfg_value_t'(32767));
				default: write_register(fqd_pkg::REG_HYSTERESIS,
					cfg_value_t'($urandom_range(200, 9000)));
			endcase
			seg_len = $urandom_range(40, 160);
			if ($urandom_range(0, 4) == 0) begin
				// noise: arbitrary pairs
				repeat (seg_len) push_sample_pair(15'($urandom), 15'($urandom), 1'b0, '0);
			end else begin
				// quadrature square waves with jitter
				quarter_len = $urandom_range(2, 10);
				forward = ($urandom_range(0, 1) == 1);
				low_lvl = $urandom_range(0, 9000);
				high_lvl = $urandom_range(23000, 32767);
				noise = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3000);
				quadrant = $urandom_range(0, 3);
				step_in_quarter = 0;
				repeat (seg_len) begin
					a = jitter_level((quadrant == 1 || quadrant == 2) ? high_lvl : low_lvl, noise);
					b = jitter_level((quadrant >= 2) ? high_lvl : low_lvl, noise);
					push_sample_pair(a, b, 1'b0, '0);
					// the odd reversal breaks the sequence
					if ($urandom_range(0, 39) == 0) forward = !forward;
					step_in_quarter++;
					if (step_in_quarter >= quarter_len) begin
						step_in_quarter = 0;
						quadrant = (quadrant + (forward ? 1 : 3)) % 4;
					end
				end
			end
		end

		settle_block();
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/fqd_pkg.sv
src/fqd_rom.sv
src/fqd_datapath.sv
src/filtered_quadrature_decoder.sv
bench/filtered_quadrature_decoder_test.sv
